### rtl/mpgnm_pkg.sv
// Shared constants, types and a helper function of the pad grid note mapper.
package mpgnm_pkg;

  // Pad grid geometry
  localparam int PAD_COUNT = 32;
  localparam int PAD_IDX_W = $clog2(PAD_COUNT);
  localparam logic [6:0] PAD_BASE = 7'd68;
  localparam logic [6:0] PAD_END  = 7'(68 + PAD_COUNT - 1);
  localparam logic [PAD_IDX_W-1:0] PAD_LAST = PAD_IDX_W'(PAD_COUNT - 1);

  // Note mapping
  localparam logic signed [8:0] NOTE_BASE = 9'sd48;
  localparam logic signed [8:0] NOTE_MAX  = 9'sd127;
  localparam logic signed [3:0] OCT_MIN   = -4'sd5;
  localparam logic signed [3:0] OCT_MAX   = 4'sd5;
  localparam logic [3:0] ROOT_MAX   = 4'd11;
  localparam logic [3:0] PITCH_LAST = 4'd11;

  // MIDI message types (high nibble of the status byte) and controllers
  localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
  localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;
  localparam logic [3:0] MIDI_CTRL     = 4'hB;
  localparam logic [6:0] CC_OCT_UP     = 7'd55;
  localparam logic [6:0] CC_OCT_DOWN   = 7'd54;

  // Packet bytes and colours
  localparam logic [7:0] HDR_NOTE       = 8'h29;
  localparam logic [7:0] HDR_LIGHT      = 8'h09;
  localparam logic [7:0] NOTE_ON_STATUS = 8'h90;
  localparam logic [6:0] COLOUR_HELD  = 7'd127;
  localparam logic [6:0] COLOUR_ROOT  = 7'd122;
  localparam logic [6:0] COLOUR_SCALE = 7'd36;
  localparam logic [6:0] COLOUR_OFF   = 7'd0;

  // Scale membership by pitch class, bit n set when interval n is in the scale.
  // Major: 0 2 4 5 7 9 11.  Natural minor: 0 2 3 5 7 8 10.
  localparam logic [11:0] MAJOR_MASK = 12'hAB5;
  localparam logic [11:0] MINOR_MASK = 12'h5AD;

  // Command queue between front and back
  localparam int CMD_FIFO_DEPTH = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOT_NOTE  = 1'b0,
    CFG_SCALE_MODE = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    REQ_PAD     = 2'd0,
    REQ_BUTTON  = 2'd1,
    REQ_LEDS    = 2'd2,
    REQ_SET_OCT = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    SCALE_MAJOR     = 2'd0,
    SCALE_MINOR     = 2'd1,
    SCALE_CHROMATIC = 2'd2
  } scale_t;

  typedef enum logic [1:0] {
    PKT_NONE  = 2'd0,
    PKT_NOTE  = 2'd1,
    PKT_LIGHT = 2'd2
  } pkt_kind_t;

  typedef enum logic [2:0] {
    OP_IGNORE  = 3'd0,
    OP_PAD_OFF = 3'd1,
    OP_PAD_ON  = 3'd2,
    OP_OCT_STEP = 3'd3,
    OP_SET_OCT = 3'd4,
    OP_LEDS    = 3'd5
  } cmd_op_t;

  // Classified request handed from front to back
  typedef struct packed {
    cmd_op_t               op;
    logic [PAD_IDX_W-1:0]  pad;
    logic [6:0]            velocity;
    logic [3:0]            channel;
    logic                  up;
    logic signed [3:0]     octave;
  } cmd_t;

  function automatic logic in_scale(scale_t mode, logic [3:0] rel);
    logic hit;
    hit = 1'b0;
    unique case (mode)
      SCALE_CHROMATIC: hit = 1'b1;
      SCALE_MINOR:     hit = (rel <= PITCH_LAST) ? MINOR_MASK[rel] : 1'b0;
      default:         hit = (rel <= PITCH_LAST) ? MAJOR_MASK[rel] : 1'b0;
    endcase
    return hit;
  endfunction

endpackage

### rtl/mpgnm_req_if.sv
// Request channel: one MIDI or control request per word.
interface mpgnm_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [7:0]        status_byte;
  logic [6:0]        data_one;
  logic [6:0]        data_two;
  logic [3:0]        midi_channel;
  logic signed [3:0] octave_value;

  modport source (output valid, req_type, status_byte, data_one, data_two,
                  midi_channel, octave_value, input ready);
  modport sink   (input valid, req_type, status_byte, data_one, data_two,
                  midi_channel, octave_value, output ready);
endinterface

### rtl/mpgnm_rsp_if.sv
// Result channel: one packet or status report per word.
interface mpgnm_rsp_if;
  logic              valid;
  logic              ready;
  logic [1:0]        packet_kind;
  logic              handled;
  logic [7:0]        pkt_byte0;
  logic [7:0]        pkt_byte1;
  logic [6:0]        pkt_byte2;
  logic [6:0]        pkt_byte3;
  logic signed [3:0] octave_now;
  logic              octave_changed;
  logic              last;

  modport source (output valid, packet_kind, handled, pkt_byte0, pkt_byte1, pkt_byte2,
                  pkt_byte3, octave_now, octave_changed, last, input ready);
  modport sink   (input valid, packet_kind, handled, pkt_byte0, pkt_byte1, pkt_byte2,
                  pkt_byte3, octave_now, octave_changed, last, output ready);
endinterface

### rtl/mpgnm_cfg_if.sv
// Configuration write channel: register index and write data per word.
interface mpgnm_cfg_if
  import mpgnm_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/midi_pad_grid_note_mapper.sv
// Top level of the pad grid note mapper: configuration registers, front, queue and back.
//
// Channels: req carries one request word (pad MIDI event, button event, LED refresh or
// set octave); rsp carries result words, each flagged last on the final word of its
// request; cfg writes root_note (index 0) and scale_mode (index 1), always ready.
// The user must see that configuration is written only while no request is in flight;
// the block itself does not enforce this. A request word passes through the command
// queue and then the result register; an LED refresh first moves the back end into
// its sweep state, then loads one light packet per pad into the single result register,
// and the back end takes no new command until the sweep is done. Other requests are
// executed as they are taken from the queue.
// A two-word command queue sits between front and back, so requests are taken while
// the back end is sweeping or the receiver stalls, until the queue is full.
// Receiver stall: the result word holds on rsp until taken; the back end then waits.
// Reset: no pad held, octave 0, root C, major scale, queue and result register empty.
module midi_pad_grid_note_mapper
  import mpgnm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  mpgnm_req_if.sink   req,
  mpgnm_rsp_if.source rsp,
  mpgnm_cfg_if.sink   cfg
);

  logic [3:0] root_note;
  scale_t     scale_mode;
  logic       front_valid;
  logic       front_ready;
  cmd_t       front_cmd;
  logic       back_valid;
  logic       back_ready;
  cmd_t       back_cmd;

  assign cfg.ready = 1'b1;

  // Hold configuration, clamping out-of-range writes
  always_ff @(posedge clk) begin
    if (rst) begin
      root_note  <= 4'd0;
      scale_mode <= SCALE_MAJOR;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_ROOT_NOTE: begin
          root_note <= (cfg.data > ROOT_MAX) ? ROOT_MAX : cfg.data;
        end
        CFG_SCALE_MODE: begin
          scale_mode <= (cfg.data[1:0] == 2'd3) ? SCALE_CHROMATIC : scale_t'(cfg.data[1:0]);
        end
        default: ;
      endcase
    end
  end

  mpgnm_front u_front (
    .req       (req),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  mpgnm_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_cmd   (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_cmd    (back_cmd)
  );

  mpgnm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (back_valid),
    .cmd_ready  (back_ready),
    .cmd        (back_cmd),
    .root_note  (root_note),
    .scale_mode (scale_mode),
    .rsp        (rsp)
  );

endmodule

### rtl/mpgnm_cmd_fifo.sv
// Short command queue decoupling the classifying front from the executing back.
module mpgnm_cmd_fifo
  import mpgnm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CMD_FIFO_DEPTH);

  cmd_t             mem [CMD_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_cmd    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store incoming words
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/mpgnm_front.sv
// Request front end: accepts request words and classifies them into commands.
module mpgnm_front
  import mpgnm_pkg::*;
(
  mpgnm_req_if.sink req,
  output logic      cmd_valid,
  input  logic      cmd_ready,
  output cmd_t      cmd
);

  logic [3:0]        msg_type;
  logic              on_grid;
  logic              is_off;
  logic              is_on;
  logic              is_step;
  logic signed [3:0] oct_clamped;

  assign req.ready = cmd_ready;
  assign cmd_valid = req.valid;

  // Decode the MIDI message
  always_comb begin
    msg_type = req.status_byte[7:4];
    on_grid  = (req.data_one >= PAD_BASE) && (req.data_one <= PAD_END);
    is_off   = (msg_type == MIDI_NOTE_OFF) ||
               ((msg_type == MIDI_NOTE_ON) && (req.data_two == 7'd0));
    is_on    = (msg_type == MIDI_NOTE_ON);
    is_step  = (msg_type == MIDI_CTRL) && (req.data_two != 7'd0) &&
               ((req.data_one == CC_OCT_UP) || (req.data_one == CC_OCT_DOWN));
    if (req.octave_value < OCT_MIN) begin
      oct_clamped = OCT_MIN;
    end else if (req.octave_value > OCT_MAX) begin
      oct_clamped = OCT_MAX;
    end else begin
      oct_clamped = req.octave_value;
    end
  end

  // Build the command word
  always_comb begin
    cmd.op       = OP_IGNORE;
    cmd.pad      = PAD_IDX_W'(req.data_one - PAD_BASE);
    cmd.velocity = req.data_two;
    cmd.channel  = req.midi_channel;
    cmd.up       = (req.data_one == CC_OCT_UP);
    cmd.octave   = oct_clamped;
    unique case (req.req_type)
      REQ_PAD: begin
        if (on_grid && is_off) begin
          cmd.op = OP_PAD_OFF;
        end else if (on_grid && is_on) begin
          cmd.op = OP_PAD_ON;
        end
      end
      REQ_BUTTON: begin
        if (is_step) begin
          cmd.op = OP_OCT_STEP;
        end
      end
      REQ_LEDS:    cmd.op = OP_LEDS;
      REQ_SET_OCT: cmd.op = OP_SET_OCT;
      default:     cmd.op = OP_IGNORE;
    endcase
  end

endmodule

### rtl/mpgnm_back.sv
// Command back end: holds pad and octave state, builds packets, sweeps LED refreshes.
module mpgnm_back
  import mpgnm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  input  logic [3:0]  root_note,
  input  scale_t      scale_mode,
  mpgnm_rsp_if.source rsp
);

  typedef enum logic {
    ST_CMD,
    ST_LEDS
  } state_t;

  state_t                 state;
  logic [PAD_COUNT-1:0]   held_pads;
  logic signed [3:0]      octave;
  logic [PAD_IDX_W-1:0]   led_idx;
  logic [3:0]             led_rel;

  logic                   out_valid;
  pkt_kind_t              out_kind;
  logic                   out_handled;
  logic [7:0]             out_b0;
  logic [7:0]             out_b1;
  logic [6:0]             out_b2;
  logic [6:0]             out_b3;
  logic signed [3:0]      out_octave;
  logic                   out_changed;
  logic                   out_last;

  logic                   slot_free;
  logic                   take_cmd;
  logic                   emit_light;
  logic                   load_word;
  logic signed [8:0]      oct_ext;
  logic signed [8:0]      note_sum;
  logic [6:0]             note;
  logic signed [3:0]      oct_step;
  logic [6:0]             colour;

  pkt_kind_t              out_kind_next;
  logic                   out_handled_next;
  logic [7:0]             out_b0_next;
  logic [7:0]             out_b1_next;
  logic [6:0]             out_b2_next;
  logic [6:0]             out_b3_next;
  logic signed [3:0]      octave_next;
  logic                   out_changed_next;
  logic                   out_last_next;

  assign slot_free  = !out_valid || rsp.ready;
  assign cmd_ready  = (state == ST_CMD) && slot_free;
  assign take_cmd   = cmd_valid && cmd_ready;
  assign emit_light = (state == ST_LEDS) && slot_free;
  assign load_word  = (take_cmd && (cmd.op != OP_LEDS)) || emit_light;

  // Map pad to note: 48 + 12*octave + root + pad, clamped to 0..127
  always_comb begin
    oct_ext  = {{5{octave[3]}}, octave};
    note_sum = (oct_ext <<< 3) + (oct_ext <<< 2) + NOTE_BASE +
               $signed(9'(root_note)) + $signed(9'(cmd.pad));
    if (note_sum < 0) begin
      note = 7'd0;
    end else if (note_sum > NOTE_MAX) begin
      note = 7'd127;
    end else begin
      note = note_sum[6:0];
    end
  end

  // Step octave one place, held within its bounds
  always_comb begin
    if (cmd.up) begin
      oct_step = (octave >= OCT_MAX) ? OCT_MAX : octave + 4'sd1;
    end else begin
      oct_step = (octave <= OCT_MIN) ? OCT_MIN : octave - 4'sd1;
    end
  end

  // Colour of the pad under the sweep
  always_comb begin
    if (held_pads[led_idx]) begin
      colour = COLOUR_HELD;
    end else if (led_rel == 4'd0) begin
      colour = COLOUR_ROOT;
    end else if (in_scale(scale_mode, led_rel)) begin
      colour = COLOUR_SCALE;
    end else begin
      colour = COLOUR_OFF;
    end
  end

  // Build the next result word and octave
  always_comb begin
    out_kind_next    = PKT_NONE;
    out_handled_next = 1'b0;
    out_b0_next      = 8'd0;
    out_b1_next      = 8'd0;
    out_b2_next      = 7'd0;
    out_b3_next      = 7'd0;
    octave_next      = octave;
    out_changed_next = 1'b0;
    out_last_next    = 1'b1;
    if (state == ST_LEDS) begin
      out_kind_next    = PKT_LIGHT;
      out_handled_next = 1'b1;
      out_b0_next      = HDR_LIGHT;
      out_b1_next      = NOTE_ON_STATUS;
      out_b2_next      = PAD_BASE + 7'(led_idx);
      out_b3_next      = colour;
      out_last_next    = (led_idx == PAD_LAST);
    end else begin
      unique case (cmd.op)
        OP_PAD_OFF: begin
          out_handled_next = 1'b1;
        end
        OP_PAD_ON: begin
          out_kind_next    = PKT_NOTE;
          out_handled_next = 1'b1;
          out_b0_next      = HDR_NOTE;
          out_b1_next      = NOTE_ON_STATUS | {4'd0, cmd.channel};
          out_b2_next      = note;
          out_b3_next      = cmd.velocity;
        end
        OP_OCT_STEP: begin
          octave_next      = oct_step;
          out_handled_next = 1'b1;
          out_changed_next = 1'b1;
        end
        OP_SET_OCT: begin
          octave_next      = cmd.octave;
          out_handled_next = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Execute commands and hold the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CMD;
      out_valid <= 1'b0;
      held_pads <= '0;
      octave    <= '0;
      led_idx   <= '0;
      led_rel   <= '0;
    end else begin
      // Raise a new word or drop the one just taken
      if (load_word) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (load_word) begin
        out_kind    <= out_kind_next;
        out_handled <= out_handled_next;
        out_b0      <= out_b0_next;
        out_b1      <= out_b1_next;
        out_b2      <= out_b2_next;
        out_b3      <= out_b3_next;
        out_octave  <= octave_next;
        out_changed <= out_changed_next;
        out_last    <= out_last_next;
      end
      // Update pad and octave state
      if (take_cmd) begin
        octave <= octave_next;
        if (cmd.op == OP_PAD_OFF) begin
          held_pads[cmd.pad] <= 1'b0;
        end else if (cmd.op == OP_PAD_ON) begin
          held_pads[cmd.pad] <= 1'b1;
        end
      end
      unique case (state)
        ST_CMD: begin
          if (take_cmd && (cmd.op == OP_LEDS)) begin
            state   <= ST_LEDS;
            led_idx <= '0;
            led_rel <= '0;
          end
        end
        ST_LEDS: begin
          if (slot_free) begin
            led_rel <= (led_rel == PITCH_LAST) ? 4'd0 : led_rel + 4'd1;
            if (led_idx == PAD_LAST) begin
              state <= ST_CMD;
            end else begin
              led_idx <= led_idx + 1'b1;
            end
          end
        end
        default: state <= ST_CMD;
      endcase
    end
  end

  // Drive the result channel
  assign rsp.valid          = out_valid;
  assign rsp.packet_kind    = out_kind;
  assign rsp.handled        = out_handled;
  assign rsp.pkt_byte0      = out_b0;
  assign rsp.pkt_byte1      = out_b1;
  assign rsp.pkt_byte2      = out_b2;
  assign rsp.pkt_byte3      = out_b3;
  assign rsp.octave_now     = out_octave;
  assign rsp.octave_changed = out_changed;
  assign rsp.last           = out_last;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench for the pad grid note mapper: directed and random MIDI requests checked against a predictor.
module tb;
  import mpgnm_pkg::*;

  typedef struct packed {
    req_kind_t  kind;
    logic [7:0] status;
    logic [6:0] d1;
    logic [6:0] d2;
    logic [3:0] chan;
    logic [3:0] oct;
  } midi_req_t;

  typedef struct packed {
    pkt_kind_t  kind;
    logic       handled;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [6:0] b2;
    logic [6:0] b3;
    logic [3:0] oct;
    logic       changed;
    logic       last;
  } pad_word_t;

  // Pad grid predictor and store of expected result words
  class note_map_scoreboard;
    logic [PAD_COUNT-1:0] held;
    logic signed [3:0]    octave;
    logic [3:0]           root;
    scale_t               scale;
    pad_word_t            expected_words[$];
    int                   fault_count;

    function new();
      held = '0;
      octave = 4'sd0;
      root = 4'd0;
      scale = SCALE_MAJOR;
      fault_count = 0;
    endfunction

    function int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function bit scale_hit(int rel);
      if (scale == SCALE_CHROMATIC) return 1'b1;
      if (scale == SCALE_MINOR) begin
        case (rel)
          0, 2, 3, 5, 7, 8, 10: return 1'b1;
          default: return 1'b0;
        endcase
      end
      case (rel)
        0, 2, 4, 5, 7, 9, 11: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void expect_word(pkt_kind_t k, logic h, logic [7:0] b0, logic [7:0] b1,
                              logic [6:0] b2, logic [6:0] b3, logic ch, logic last);
      pad_word_t w;
      w.kind = k;
      w.handled = h;
      w.b0 = b0;
      w.b1 = b1;
      w.b2 = b2;
      w.b3 = b3;
      w.oct = octave;
      w.changed = ch;
      w.last = last;
      expected_words.push_back(w);
    endfunction

    function void write_reg(cfg_reg_t idx, logic [3:0] v);
      if (idx == CFG_ROOT_NOTE) begin
        root = (v > ROOT_MAX) ? ROOT_MAX : v;
      end else if (v[1:0] == 2'd3) begin
        scale = SCALE_CHROMATIC;
      end else begin
        scale = scale_t'(v[1:0]);
      end
    endfunction

    function void note_request(midi_req_t r);
      logic [3:0]           nib;
      logic                 on_grid;
      logic [PAD_IDX_W-1:0] pad;
      logic [6:0]           colour;
      int                   val;
      nib = r.status[7:4];
      on_grid = (r.d1 >= PAD_BASE) && (r.d1 <= PAD_END);
      pad = PAD_IDX_W'(r.d1 - PAD_BASE);
      case (r.kind)
        REQ_PAD: begin
          if (on_grid && (nib == MIDI_NOTE_OFF || (nib == MIDI_NOTE_ON && r.d2 == 7'd0))) begin
            held[pad] = 1'b0;
            expect_word(PKT_NONE, 1'b1, 8'd0, 8'd0, 7'd0, 7'd0, 1'b0, 1'b1);
          end else if (on_grid && nib == MIDI_NOTE_ON) begin
            val = int'(NOTE_BASE) + 12 * int'(octave) + int'(root) + int'(pad);
            val = clamp(val, 0, 127);
            held[pad] = 1'b1;
            expect_word(PKT_NOTE, 1'b1, HDR_NOTE, NOTE_ON_STATUS | {4'd0, r.chan},
                        7'(val), r.d2, 1'b0, 1'b1);
          end else begin
            expect_word(PKT_NONE, 1'b0, 8'd0, 8'd0, 7'd0, 7'd0, 1'b0, 1'b1);
          end
        end
        REQ_BUTTON: begin
          if (nib == MIDI_CTRL && r.d2 != 7'd0 && (r.d1 == CC_OCT_UP || r.d1 == CC_OCT_DOWN)) begin
            val = int'(octave) + ((r.d1 == CC_OCT_UP) ? 1 : -1);
            octave = 4'(clamp(val, -5, 5));
            expect_word(PKT_NONE, 1'b1, 8'd0, 8'd0, 7'd0, 7'd0, 1'b1, 1'b1);
          end else begin
            expect_word(PKT_NONE, 1'b0, 8'd0, 8'd0, 7'd0, 7'd0, 1'b0, 1'b1);
          end
        end
        REQ_LEDS: begin
          for (int i = 0; i < PAD_COUNT; i++) begin
            if (held[i]) colour = COLOUR_HELD;
            else if (i % 12 == 0) colour = COLOUR_ROOT;
            else if (scale_hit(i % 12)) colour = COLOUR_SCALE;
            else colour = COLOUR_OFF;
            expect_word(PKT_LIGHT, 1'b1, HDR_LIGHT, NOTE_ON_STATUS, PAD_BASE + 7'(i), colour,
                        1'b0, i == PAD_COUNT - 1);
          end
        end
        default: begin
          octave = 4'(clamp(int'($signed(r.oct)), -5, 5));
          expect_word(PKT_NONE, 1'b1, 8'd0, 8'd0, 7'd0, 7'd0, 1'b0, 1'b1);
        end
      endcase
    endfunction

    function void check_word(pad_word_t got);
      pad_word_t want;
      if (expected_words.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected word: kind %0d handled %0d bytes %02h %02h %02h %02h",
                   got.kind, got.handled, got.b0, got.b1, got.b2, got.b3);
        return;
      end
      want = expected_words.pop_front();
      if (got.kind !== want.kind || got.handled !== want.handled || got.b0 !== want.b0 ||
          got.b1 !== want.b1 || got.b2 !== want.b2 || got.b3 !== want.b3 ||
          got.oct !== want.oct || got.changed !== want.changed || got.last !== want.last) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("word mismatch at %0t ns", $realtime);
          $display("  want: kind %0d handled %0d bytes %02h %02h %02h %02h oct %0d chg %0d last %0d",
                   want.kind, want.handled, want.b0, want.b1, want.b2, want.b3,
                   $signed(want.oct), want.changed, want.last);
          $display("  got:  kind %0d handled %0d bytes %02h %02h %02h %02h oct %0d chg %0d last %0d",
                   got.kind, got.handled, got.b0, got.b1, got.b2, got.b3,
                   $signed(got.oct), got.changed, got.last);
        end
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic calm;
  logic hold_go;

  mpgnm_req_if req_ch();
  mpgnm_rsp_if rsp_ch();
  mpgnm_cfg_if cfg_ch();

  midi_pad_grid_note_mapper dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  note_map_scoreboard sb = new();
  midi_req_t seen_req;
  pad_word_t seen_word;

  always #2 clk = ~clk;

  // Note every accepted word on each channel
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready)
        sb.write_reg(cfg_reg_t'(cfg_ch.index), cfg_ch.data);
      if (req_ch.valid && req_ch.ready) begin
        seen_req.kind = req_kind_t'(req_ch.req_type);
        seen_req.status = req_ch.status_byte;
        seen_req.d1 = req_ch.data_one;
        seen_req.d2 = req_ch.data_two;
        seen_req.chan = req_ch.midi_channel;
        seen_req.oct = req_ch.octave_value;
        sb.note_request(seen_req);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen_word.kind = pkt_kind_t'(rsp_ch.packet_kind);
        seen_word.handled = rsp_ch.handled;
        seen_word.b0 = rsp_ch.pkt_byte0;
        seen_word.b1 = rsp_ch.pkt_byte1;
        seen_word.b2 = rsp_ch.pkt_byte2;
        seen_word.b3 = rsp_ch.pkt_byte3;
        seen_word.oct = rsp_ch.octave_now;
        seen_word.changed = rsp_ch.octave_changed;
        seen_word.last = rsp_ch.last;
        sb.check_word(seen_word);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= 19);
      end
    end
  end

  function automatic midi_req_t mk(req_kind_t k, logic [7:0] s, logic [6:0] a, logic [6:0] b,
                                   logic [3:0] c, logic [3:0] o);
    midi_req_t r;
    r.kind = k;
    r.status = s;
    r.d1 = a;
    r.d2 = b;
    r.chan = c;
    r.oct = o;
    return r;
  endfunction

  // Mostly well-formed pad, button, octave and LED requests; the rest is raw noise
  function automatic midi_req_t random_req();
    midi_req_t r;
    int pick;
    r = mk(req_kind_t'($urandom_range(3)), 8'($urandom), 7'($urandom), 7'($urandom),
           4'($urandom), 4'($urandom));
    pick = $urandom_range(99);
    if (pick < 25) begin
      r.kind = REQ_PAD;
      r.status = {MIDI_NOTE_ON, 4'($urandom)};
      r.d1 = PAD_BASE + 7'($urandom_range(PAD_COUNT - 1));
      r.d2 = 7'($urandom_range(127, 1));
    end else if (pick < 43) begin
      r.kind = REQ_PAD;
      r.d1 = PAD_BASE + 7'($urandom_range(PAD_COUNT - 1));
      if ($urandom_range(1)) begin
        r.status = {MIDI_NOTE_OFF, 4'($urandom)};
      end else begin
        r.status = {MIDI_NOTE_ON, 4'($urandom)};
        r.d2 = 7'd0;
      end
    end else if (pick < 58) begin
      r.kind = REQ_BUTTON;
      r.status = {MIDI_CTRL, 4'($urandom)};
      r.d1 = $urandom_range(1) ? CC_OCT_UP : CC_OCT_DOWN;
      r.d2 = ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(127, 1));
    end else if (pick < 66) begin
      r.kind = REQ_SET_OCT;
    end else if (pick < 73) begin
      r.kind = REQ_LEDS;
    end
    return r;
  endfunction

  // Offer one request word and hold it until taken
  task automatic send_req(midi_req_t r);
    while (!calm && $urandom_range(99) < 19) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.req_type <= r.kind;
    req_ch.status_byte <= r.status;
    req_ch.data_one <= r.d1;
    req_ch.data_two <= r.d2;
    req_ch.midi_channel <= r.chan;
    req_ch.octave_value <= r.oct;
    req_ch.valid <= 1'b1;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Write both registers back to back
  task automatic cfg_pair(logic [3:0] root_val, logic [3:0] scale_val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_ROOT_NOTE;
    cfg_ch.data <= root_val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= CFG_SCALE_MODE;
    cfg_ch.data <= scale_val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop offering and wait for every expected word, then cover the pipeline latency
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst <= 1'b1;
    calm <= 1'b0;
    hold_go <= 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_PAD;
    req_ch.status_byte <= 8'd0;
    req_ch.data_one <= 7'd0;
    req_ch.data_two <= 7'd0;
    req_ch.midi_channel <= 4'd0;
    req_ch.octave_value <= 4'd0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_ROOT_NOTE;
    cfg_ch.data <= 4'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    cfg_pair(4'd0, 4'(SCALE_MAJOR));

    // Directed: octave clamps, note clamps at both ends, note-off forms, off-grid and
    // foreign types, buttons at the octave bounds and rejected buttons, light sweeps
    send_req(mk(REQ_SET_OCT, 8'h00, 7'd0, 7'd0, 4'd0, 4'(-8)));
    send_req(mk(REQ_PAD, 8'h9F, 7'd68, 7'd127, 4'd15, 4'd0));
    send_req(mk(REQ_PAD, 8'h90, 7'd99, 7'd1, 4'd0, 4'd0));
    send_req(mk(REQ_SET_OCT, 8'hFF, 7'd127, 7'd127, 4'd15, 4'd7));
    send_req(mk(REQ_PAD, 8'h95, 7'd99, 7'd64, 4'd9, 4'd0));
    send_req(mk(REQ_PAD, 8'h90, 7'd80, 7'd100, 4'd3, 4'd0));
    send_req(mk(REQ_LEDS, 8'h00, 7'd0, 7'd0, 4'd0, 4'd0));
    send_req(mk(REQ_PAD, 8'h80, 7'd68, 7'd55, 4'd0, 4'd0));
    send_req(mk(REQ_PAD, 8'h90, 7'd99, 7'd0, 4'd0, 4'd0));
    send_req(mk(REQ_PAD, 8'h90, 7'd67, 7'd20, 4'd0, 4'd0));
    send_req(mk(REQ_PAD, 8'h90, 7'd100, 7'd20, 4'd0, 4'd0));
    send_req(mk(REQ_PAD, 8'hA0, 7'd70, 7'd10, 4'd0, 4'd0));
    send_req(mk(REQ_PAD, 8'h00, 7'd0, 7'd0, 4'd0, 4'd0));
    send_req(mk(REQ_PAD, 8'hFF, 7'd127, 7'd127, 4'd15, 4'd15));
    send_req(mk(REQ_BUTTON, 8'hB0, 7'd55, 7'd1, 4'd0, 4'd0));
    send_req(mk(REQ_BUTTON, 8'hBF, 7'd54, 7'd127, 4'd0, 4'd0));
    send_req(mk(REQ_BUTTON, 8'hB0, 7'd55, 7'd0, 4'd0, 4'd0));
    send_req(mk(REQ_BUTTON, 8'hB0, 7'd53, 7'd5, 4'd0, 4'd0));
    send_req(mk(REQ_BUTTON, 8'h90, 7'd55, 7'd5, 4'd0, 4'd0));
    send_req(mk(REQ_SET_OCT, 8'h00, 7'd0, 7'd0, 4'd0, 4'(-6)));
    send_req(mk(REQ_BUTTON, 8'hB3, 7'd54, 7'd9, 4'd0, 4'd0));
    send_req(mk(REQ_LEDS, 8'h00, 7'd0, 7'd0, 4'd0, 4'd0));
    send_req(mk(REQ_SET_OCT, 8'h00, 7'd0, 7'd0, 4'd0, 4'd0));
    drain();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: cfg_pair(4'd11, 4'(SCALE_MINOR));
        1: cfg_pair(4'd15, 4'd3);
        2: cfg_pair(4'd5, 4'(SCALE_CHROMATIC));
        3: cfg_pair(4'd0, 4'(SCALE_MAJOR));
        default: cfg_pair(4'($urandom), 4'($urandom));
      endcase
      calm <= (ph == 0);
      if (ph == 1) hold_go <= 1'b1;
      repeat (78) send_req(random_req());
      drain();
    end

    if (sb.fault_count == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### midi_pad_grid_note_mapper.f
rtl/mpgnm_pkg.sv
rtl/mpgnm_req_if.sv
rtl/mpgnm_rsp_if.sv
rtl/mpgnm_cfg_if.sv
rtl/mpgnm_cmd_fifo.sv
rtl/mpgnm_front.sv
rtl/mpgnm_back.sv
rtl/midi_pad_grid_note_mapper.sv
sim/tb.sv
